// ===== rtl/core/four_axis_pid_velocity_controller_defines.svh =====
// Assertion macros for the four-axis PID velocity controller.
// No dependencies; included by the top level.
`ifndef FOUR_AXIS_PID_VELOCITY_CONTROLLER_DEFINES_SVH
`define FOUR_AXIS_PID_VELOCITY_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FAPID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FAPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fapid_pkg.sv =====
// Shared types and constants of the four-axis PID velocity controller.
// No dependencies.
`timescale 1ns / 1ps

package fapid_pkg;

  localparam int POS_WIDTH      = 24;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int ERR_W          = POS_WIDTH + 1;
  localparam int INTEG_W        = 17;
  localparam int DT_W           = 20;
  localparam int DIV_W          = 46;
  localparam int DIV_CNT_W      = 6;
  localparam int IN_W           = 200;
  localparam int OUT_W          = 64;

  localparam logic [2:0] REG_GAINS_X    = 3'd0;
  localparam logic [2:0] REG_GAINS_Y    = 3'd1;
  localparam logic [2:0] REG_GAINS_Z    = 3'd2;
  localparam logic [2:0] REG_GAINS_YAW  = 3'd3;
  localparam logic [2:0] REG_SPEED_LIM  = 3'd4;
  localparam logic [2:0] REG_INTEG_LIM  = 3'd5;
  localparam logic [2:0] REG_DEADZONES  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_ERR, ST_DDIV, ST_DMUL, ST_DMUL2,
    ST_IDIV, ST_UPD, ST_KI, ST_OUT, ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/core/fapid_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned.
// Depends on fapid_pkg.
`timescale 1ns / 1ps

module fapid_div import fapid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DT_W-1:0]      rem;
  logic [DT_W-1:0]      dvsr;
  logic [DIV_W-1:0]     q;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DT_W:0]        shifted;
  logic                 fits;

  assign shifted = {rem, q[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      q    <= req.dividend;
      dvsr <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DT_W'(shifted - {1'b0, dvsr});
      end else begin
        rem <= shifted[DT_W-1:0];
      end
      q <= {q[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = q;

endmodule

// ===== rtl/core/four_axis_pid_velocity_controller.sv =====
// Four-axis PID velocity controller: sequencer, axis state memory, datapath.
// Depends on fapid_pkg, fapid_div and four_axis_pid_velocity_controller_defines.svh.
//
//  channel | direction | handshake                  | payload
//  s_      | in        | s_tvalid / s_tready         | s_tdata, one tick
//  m_      | out       | m_tvalid / m_tready         | m_tdata, four commands
//  wr_     | in        | wr_en                       | wr_index, wr_data
//
// Axes run one after another (the 46-step serial division of the error change by the
// elapsed time dominates each axis), and s_tready returns once the result of a tick
// has moved into the output register.
// Per-axis state sits in a 4-entry memory with registered read; valid bits
// cleared by rst make unwritten entries read as zero. rst is synchronous.
// The next tick is accepted while a result still waits in the output register;
// the last step holds until that register is free.
`timescale 1ns / 1ps
`include "four_axis_pid_velocity_controller_defines.svh"

module four_axis_pid_velocity_controller import fapid_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // meas_x, meas_y, meas_z, meas_yaw, target_x, target_y, target_z,
  // target_yaw, elapsed_us, zero pad
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // vel_x, vel_y, vel_z, yaw_rate
  output logic [OUT_W-1:0] m_tdata,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [47:0]      wr_data
);

  // configuration
  logic [47:0] gains [4];
  logic [47:0] speed_limits;
  logic [47:0] integral_limits;
  logic [31:0] deadzones;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) gains[k] <= '0;
      speed_limits    <= '0;
      integral_limits <= '0;
      deadzones       <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_GAINS_X:   gains[0] <= wr_data;
        REG_GAINS_Y:   gains[1] <= wr_data;
        REG_GAINS_Z:   gains[2] <= wr_data;
        REG_GAINS_YAW: gains[3] <= wr_data;
        REG_SPEED_LIM: speed_limits <= wr_data;
        REG_INTEG_LIM: integral_limits <= wr_data;
        REG_DEADZONES: deadzones <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [1:0]      axis;
  logic [195:0]    tick;
  logic [DT_W-1:0] dt;

  // axis state memory: {prev_err, integ}
  logic [ERR_W+INTEG_W-1:0] mem [4];
  logic [ERR_W+INTEG_W-1:0] mem_q;
  logic [3:0]               mem_valid;
  logic                     mem_q_valid;
  logic                     mem_we;

  logic signed [ERR_W-1:0]   e_reg;
  logic signed [ERR_W-1:0]   prev_reg;
  logic signed [INTEG_W-1:0] integ_reg;
  logic                      d_neg;
  logic signed [41:0]        pe;
  logic [33:0]               kdlo;
  logic [45:0]               eprod;
  logic [17:0]               iq;
  logic signed [52:0]        pd;
  logic signed [INTEG_W-1:0] i_new;
  logic signed [33:0]        kii;
  logic [15:0]               lane [4];

  div_req_t div_req;
  div_rsp_t div_rsp;

  fapid_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // per-axis configuration
  logic [15:0] kp, ki, kd, imax;
  logic [14:0] vmax;
  always_comb begin
    kp = gains[axis][15:0];
    ki = gains[axis][31:16];
    kd = gains[axis][47:32];
    case (axis)
      2'd2: begin
        vmax = speed_limits[30:16];
        imax = integral_limits[31:16];
      end
      2'd3: begin
        vmax = speed_limits[46:32];
        imax = integral_limits[47:32];
      end
      default: begin
        vmax = speed_limits[14:0];
        imax = integral_limits[15:0];
      end
    endcase
  end

  // error with deadzone for the current axis
  logic signed [ERR_W-1:0] e_raw, e_dz;
  logic [ERR_W-1:0]        e_raw_mag;
  logic [15:0]             yaw_diff;
  logic [23:0]             mx, tx;
  always_comb begin
    mx = tick[24*axis +: 24];
    tx = tick[88 + 24*axis +: 24];
    yaw_diff = tick[175:160] - tick[87:72];
    if (axis == 2'd3) begin
      e_raw = {{(ERR_W-16){yaw_diff[15]}}, yaw_diff};
    end else begin
      e_raw = $signed({tx[23], tx}) - $signed({mx[23], mx});
    end
    e_raw_mag = e_raw[ERR_W-1] ? ERR_W'(-e_raw) : e_raw;
    if (axis == 2'd3) begin
      e_dz = (e_raw_mag < {9'd0, deadzones[31:16]}) ? '0 : e_raw;
    end else begin
      e_dz = (e_raw_mag < {9'd0, deadzones[15:0]}) ? '0 : e_raw;
    end
  end

  // previous error straight from the memory read, used in ERR only
  assign prev_reg = mem_q_valid ? $signed(mem_q[ERR_W+INTEG_W-1:INTEG_W]) : '0;

  // datapath terms
  logic signed [ERR_W:0]   diff;
  logic [ERR_W:0]          diff_mag;
  logic [35:0]             dnum;
  logic [ERR_W-1:0]        e_mag;
  logic [32:0]             kdhi;
  logic [50:0]             pdd;
  logic signed [52:0]      pd_sum;
  logic signed [23:0]      lim;
  logic                    sat;
  logic [54:0]             iprod;
  logic [17:0]             iq_next;
  logic signed [35:0]      step, isum, imax_s;
  logic signed [53:0]      tot;
  logic [53:0]             tmag;
  logic [45:0]             tsh;
  logic [14:0]             vout;
  always_comb begin
    diff     = $signed({e_reg[ERR_W-1], e_reg}) - $signed({prev_reg[ERR_W-1], prev_reg});
    diff_mag = diff[ERR_W] ? (ERR_W+1)'(-diff) : diff;
    dnum     = {10'd0, diff_mag} * 36'd1000;
    e_mag    = e_reg[ERR_W-1] ? ERR_W'(-e_reg) : e_reg;
    kdhi     = kd * div_rsp.quo[34:18];
    pdd      = {kdhi, 18'd0} + {17'd0, kdlo};
    pd_sum   = d_neg ? 53'(pe) - $signed({2'b00, pdd}) : 53'(pe) + $signed({2'b00, pdd});
    lim      = $signed({1'b0, vmax, 8'd0});
    sat      = (pd > 53'(lim) && e_reg > 0) || (pd < -53'(lim) && e_reg < 0);
    // |e|*dt/1000 by reciprocal (2^37/1000 rounded up), exact below 131072000;
    // larger steps only need to push the integrator onto its limit
    iprod    = eprod[26:0] * 28'd137438954;
    iq_next  = (eprod >= 46'd131072000) ? 18'h20000 : iprod[54:37];
    step     = e_reg[ERR_W-1] ? -$signed({18'd0, iq}) : $signed({18'd0, iq});
    isum     = sat ? 36'(integ_reg) : 36'(integ_reg) + step;
    imax_s   = $signed({20'd0, imax});
    if (isum > imax_s) isum = imax_s;
    if (isum < -imax_s) isum = -imax_s;
    tot      = 54'(pd) + 54'(kii);
    tmag     = tot[53] ? 54'(-tot) : tot;
    tsh      = tmag[53:GAIN_FRAC_BITS];
    vout     = (tsh > {31'd0, vmax}) ? vmax : tsh[14:0];
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next      = state;
    div_req.start    = 1'b0;
    div_req.dividend = {10'd0, dnum};
    div_req.divisor  = dt;
    mem_we          = 1'b0;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_RD;
      ST_RD:    state_next = ST_ERR;
      ST_ERR: begin
        div_req.start = 1'b1;
        state_next    = ST_DDIV;
      end
      ST_DDIV:  if (div_rsp.done) state_next = ST_DMUL;
      ST_DMUL:  state_next = ST_DMUL2;
      ST_DMUL2: state_next = ST_IDIV;
      ST_IDIV:  state_next = ST_UPD;
      ST_UPD: begin
        mem_we     = 1'b1;
        state_next = ST_KI;
      end
      ST_KI:    state_next = ST_OUT;
      ST_OUT:   state_next = (axis == 2'd3) ? ST_FIN : ST_RD;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis      <= '0;
      mem_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (state == ST_IDLE && s_tvalid) axis <= '0;
      if (state == ST_OUT) axis <= axis + 1'b1;
      if (mem_we) mem_valid[axis] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[axis] <= {e_reg, isum[INTEG_W-1:0]};
    mem_q       <= mem[axis];
    mem_q_valid <= mem_valid[axis];
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      tick <= s_tdata[195:0];
      dt   <= (s_tdata[195:176] == '0 || s_tdata[195:176] > DT_W'(500000))
              ? DT_W'(1000) : s_tdata[195:176];
    end
    case (state)
      ST_RD:  e_reg <= e_dz;
      ST_ERR: integ_reg <= mem_q_valid ? $signed(mem_q[INTEG_W-1:0]) : '0;
      default: ;
    endcase
    if (state == ST_ERR) d_neg <= diff[ERR_W];
    if (state == ST_DMUL) begin
      kdlo  <= kd * div_rsp.quo[17:0];
      pe    <= $signed({1'b0, kp}) * e_reg;
      eprod <= 46'(e_mag) * 46'(dt);
    end
    if (state == ST_DMUL2) pd <= pd_sum;
    if (state == ST_IDIV) iq <= iq_next;
    if (state == ST_UPD) i_new <= isum[INTEG_W-1:0];
    if (state == ST_KI) kii <= $signed({1'b0, ki}) * i_new;
    if (state == ST_OUT) lane[axis] <= tot[53] ? 16'(-$signed({1'b0, vout}))
                                               : {1'b0, vout};
    if (state == ST_FIN && out_free) m_tdata <= {lane[3], lane[2], lane[1], lane[0]};
  end

  // ERR relies on mem_q read in RD; a second start while busy would corrupt the running division
  `FAPID_ASSERT_NOW(a_div_idle_on_start, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `FAPID_ASSERT_NEXT(a_accept_blocks, s_tvalid && s_tready, !s_tready, "second item taken mid-tick")
  `FAPID_ASSERT_NOW(a_fin_last_axis, state == ST_FIN, axis == 2'd0, "result issued before all axes ran")
  `FAPID_ASSERT_NOW(a_integ_bound, state == ST_KI, i_new <= $signed({1'b0, imax}) && i_new >= -$signed({1'b0, imax}), "integrator beyond its limit")

endmodule

// ===== tb/sv/four_axis_pid_velocity_controller_tb.sv =====
// Self-checking bench for the four-axis PID velocity controller.
// Depends on fapid_pkg and the controller RTL; holds its own PID predictor.
`timescale 1ns / 1ps

module four_axis_pid_velocity_controller_tb;
  import fapid_pkg::*;

  typedef struct {
    logic signed [23:0] mx, my, mz, tx, ty, tz;
    logic [15:0] myaw, tyaw;
    logic [19:0] el;
  } tick_t;

  typedef logic [63:0] vel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [47:0] wr_data = '0;

  four_axis_pid_velocity_controller DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [47:0] gain_r [4];
  logic [47:0] spd_lim, int_lim;
  logic [31:0] dz_r;
  longint prev_err [4];
  longint integ [4];

  tick_t pending_ticks [$];
  vel_t expected_vels [$];
  int errors = 0;
  bit in_acc = 1'b0;
  int burst = 0;
  int gap = 0;
  int stall = 0;

  function automatic longint pid_axis(int ax, longint e, longint dt, longint vmax,
                                      longint imax);
    longint kp, ki, kd, d, pd, lim, i, tot, mag;
    bit sat;
    kp = gain_r[ax][15:0];
    ki = gain_r[ax][31:16];
    kd = gain_r[ax][47:32];
    d = ((e - prev_err[ax]) * 1000) / dt;
    pd = kp * e + kd * d;
    lim = vmax <<< GAIN_FRAC_BITS;
    sat = (pd > lim && e > 0) || (pd < -lim && e < 0);
    i = integ[ax];
    if (!sat) i += (e * dt) / 1000;
    if (i > imax) i = imax;
    if (i < -imax) i = -imax;
    integ[ax] = i;
    prev_err[ax] = e;
    tot = pd + ki * i;
    mag = tot < 0 ? -tot : tot;
    mag = mag >>> GAIN_FRAC_BITS;
    if (mag > vmax) mag = vmax;
    return tot < 0 ? -mag : mag;
  endfunction

  function automatic longint apply_dz(longint e, longint dz);
    longint m;
    m = e < 0 ? -e : e;
    return m < dz ? 0 : e;
  endfunction

  function automatic vel_t predict_velocities(tick_t t);
    longint dt, e [4], dzp, dzy;
    logic [15:0] yd;
    vel_t v;
    dt = (t.el == 0 || t.el > 500000) ? 1000 : longint'(t.el);
    dzp = longint'(dz_r[15:0]);
    dzy = longint'(dz_r[31:16]);
    e[0] = apply_dz(longint'(t.tx) - longint'(t.mx), dzp);
    e[1] = apply_dz(longint'(t.ty) - longint'(t.my), dzp);
    e[2] = apply_dz(longint'(t.tz) - longint'(t.mz), dzp);
    yd = t.tyaw - t.myaw;
    e[3] = apply_dz(longint'($signed(yd)), dzy);
    v[15:0]  = 16'(pid_axis(0, e[0], dt, longint'(spd_lim[14:0]),
                            longint'(int_lim[15:0])));
    v[31:16] = 16'(pid_axis(1, e[1], dt, longint'(spd_lim[14:0]),
                            longint'(int_lim[15:0])));
    v[47:32] = 16'(pid_axis(2, e[2], dt, longint'(spd_lim[30:16]),
                            longint'(int_lim[31:16])));
    v[63:48] = 16'(pid_axis(3, e[3], dt, longint'(spd_lim[46:32]),
                            longint'(int_lim[47:32])));
    return v;
  endfunction

  // input handshake seen at the rising edge
  always @(posedge clk) in_acc <= !rst && s_tvalid && s_tready;

  // driver: bursts with random gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_acc) begin
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          gap <= gap - 1;
        end else if (pending_ticks.size() > 0) begin
          tick_t t;
          t = pending_ticks.pop_front();
          s_tdata <= {4'd0, t.el, t.tyaw, t.tz, t.ty, t.tx, t.myaw, t.mz, t.my, t.mx};
          s_tvalid <= 1'b1;
          expected_vels.push_back(predict_velocities(t));
          if (burst > 0) burst <= burst - 1;
          else begin
            burst <= $urandom_range(0, 6);
            gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 500);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      // receiver stall pattern
      if (stall > 0) begin
        stall <= stall - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall <= $urandom_range(1, 600);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_vels.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        vel_t x;
        x = expected_vels.pop_front();
        for (int k = 0; k < 4; k++)
          if (x[16*k +: 16] !== m_tdata[16*k +: 16]) begin
            $display("%0t: axis %0d expected %0d got %0d", $time, k,
                     $signed(x[16*k +: 16]), $signed(m_tdata[16*k +: 16]));
            errors++;
          end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_GAINS_X, REG_GAINS_Y, REG_GAINS_Z, REG_GAINS_YAW: gain_r[idx[1:0]] = val;
      REG_SPEED_LIM: spd_lim = val;
      REG_INTEG_LIM: int_lim = val;
      REG_DEADZONES: dz_r = val[31:0];
      default: ;
    endcase
  endtask

  task automatic drain_ticks();
    while (pending_ticks.size() != 0 || s_tvalid || expected_vels.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_pos(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 4000) - 2000);
      default: return 24'($urandom_range(0, 60000) - 30000);
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int m;
    m = $urandom_range(0, 3);
    t.mx = rand_pos(m); t.my = rand_pos(m); t.mz = rand_pos(m);
    t.tx = rand_pos(m); t.ty = rand_pos(m); t.tz = rand_pos(m);
    t.myaw = 16'($urandom); t.tyaw = 16'($urandom);
    case ($urandom_range(0, 5))
      0: t.el = 20'd0;
      1: t.el = 20'($urandom);
      2: t.el = 20'($urandom_range(499990, 500010));
      default: t.el = 20'($urandom_range(1, 200000));
    endcase
    return t;
  endfunction

  task automatic random_config(bit extreme);
    for (int k = 0; k < 4; k++)
      write_reg(3'(k), extreme ? 48'hFFFF_FFFF_FFFF
                               : 48'({$urandom, $urandom}) & 48'h0FFF_0FFF_FFFF);
    write_reg(REG_SPEED_LIM, extreme ? 48'hFFFF_FFFF_FFFF : 48'({$urandom, $urandom}));
    write_reg(REG_INTEG_LIM, extreme ? 48'hFFFF_FFFF_FFFF : 48'({$urandom, $urandom}));
    write_reg(REG_DEADZONES, extreme ? 48'h0 : {16'h0, 16'($urandom_range(0, 300)),
              16'($urandom_range(0, 300))});
  endtask

  initial begin
    tick_t t;
    for (int k = 0; k < 4; k++) begin
      gain_r[k] = '0; prev_err[k] = 0; integ[k] = 0;
    end
    spd_lim = '0; int_lim = '0; dz_r = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // zero limits first: outputs forced to zero
    t = rand_tick();
    pending_ticks.push_back(t);
    drain_ticks();
    write_reg(3'd7, 48'hFFFF_FFFF_FFFF); // unknown index, ignored
    random_config(1'b1);
    // directed: field extremes, half-turn yaw, bad elapsed times
    t = '{mx: 24'h800000, my: 24'h7FFFFF, mz: 0, tx: 24'h7FFFFF, ty: 24'h800000,
          tz: 0, myaw: 16'h0000, tyaw: 16'h8000, el: 0};
    pending_ticks.push_back(t);
    t = '{mx: 24'h7FFFFF, my: 24'h800000, mz: 24'h800000, tx: 24'h800000,
          ty: 24'h7FFFFF, tz: 24'h7FFFFF, myaw: 16'hFFFF, tyaw: 16'h0000, el: 20'hFFFFF};
    pending_ticks.push_back(t);
    t = '{mx: 0, my: 0, mz: 0, tx: 5, ty: -5, tz: 1, myaw: 16'h8000, tyaw: 0,
          el: 500000};
    pending_ticks.push_back(t);
    t = '{mx: 0, my: 0, mz: 0, tx: 5, ty: -5, tz: 1, myaw: 100, tyaw: 90, el: 500001};
    pending_ticks.push_back(t);
    t = '{mx: 0, my: 0, mz: 0, tx: 0, ty: 0, tz: 0, myaw: 0, tyaw: 0, el: 1};
    pending_ticks.push_back(t);
    drain_ticks();
    write_reg(REG_DEADZONES, 48'h0000_FFFF_FFFF);
    for (int n = 0; n < 6; n++) pending_ticks.push_back(rand_tick());
    drain_ticks();
    for (int ph = 0; ph < 7; ph++) begin
      random_config(ph == 3);
      for (int n = 0; n < 250; n++) pending_ticks.push_back(rand_tick());
      drain_ticks();
    end
    if (errors == 0) $display("four_axis_pid_velocity_controller_tb OK");
    else $display("four_axis_pid_velocity_controller_tb NOT OK");
    $finish;
  end

  initial begin
    #200ms;
    $display("four_axis_pid_velocity_controller_tb NOT OK");
    $finish;
  end
endmodule
